// ----- hw/rtl/dia_pkg.sv -----
// shared types, constants and calendar tables for the date interval adder
`timescale 1ns / 1ps
package dia_pkg;

  typedef enum logic [1:0] {
    FN_DAYS   = 2'd0,
    FN_MONTHS = 2'd1,
    FN_YEARS  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNIT  = 2'd2
  } status_t;

  // register stages of the split unit and of the rebuild unit
  localparam int SIDE_DEPTH = 6;
  localparam int TAIL_DEPTH = 4;

  // day count limits and year limits
  localparam logic signed [32:0] DAYS_MIN = -33'sd11000000;
  localparam logic signed [32:0] DAYS_MAX = 33'sd11000000;
  localparam logic signed [33:0] YEAR_MIN = -34'sd32767;
  localparam logic signed [33:0] YEAR_MAX = 34'sd32767;

  // offsets that make dividends non-negative (multiples of the divisor)
  localparam logic [25:0] U_OFS    = 26'd12407228;  // 719468 + 80 eras
  localparam logic [15:0] Y_OFS    = 16'd32000;     // 80 eras of 400 years
  localparam logic [21:0] UA_OFS   = 22'd1048584;   // 12 * 87382
  localparam logic [18:0] UA_QOFS  = 19'd87382;
  localparam logic [16:0] V_OFS    = 17'd32800;     // 82 eras of 400 years
  localparam logic [25:0] RES_OFS  = 26'd12699422;  // 719468 + 82 eras of days
  localparam logic [24:0] ERA_DAYS = 25'd146097;

  // reciprocals for exact division by constants
  localparam logic [25:0] M_ERA   = 26'd60207212;  // /146097, shift 43
  localparam logic [18:0] M_1460  = 19'd367720;    // shift 29
  localparam logic [18:0] M_36524 = 19'd470373;    // shift 34
  localparam logic [18:0] M_365   = 19'd367720;    // shift 27
  localparam logic [9:0]  M_100S  = 10'd656;       // small values, shift 16
  localparam logic [11:0] M_153   = 12'd3427;      // shift 19
  localparam logic [22:0] M_12    = 23'd5592406;   // shift 26
  localparam logic [17:0] M_400   = 18'd167773;    // shift 26
  localparam logic [17:0] M_100   = 18'd167773;    // shift 24

  typedef struct packed {
    logic signed [16:0] y;
    logic [3:0]         mon0;  // month minus one
    logic [4:0]         day;
  } date_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic [3:0]         mon;   // 1..12
    logic [4:0]         day;
  } ymd_t;

  typedef struct packed {
    logic               valid;
    func_t              func;
    logic               start_bad;
    logic               day_bad;
    logic [24:0]        day_res;
    logic               amt_big;
    logic signed [31:0] amt;
    logic [21:0]        ua;
    logic [17:0]        q12;
    logic [3:0]         add_m;
    logic signed [18:0] add_y;
  } side_t;

  typedef struct packed {
    logic        valid;
    func_t       func;
    logic        start_bad;
    logic        day_bad;
    logic [24:0] day_res;
    logic        ymd_bad;
  } tail_t;

  // days before a month, months counted from march
  function automatic logic [8:0] mday_tbl(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] r;
    unique case (mon)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/dia_split.sv -----
// pipelined split of a day count into year, month and day
`timescale 1ns / 1ps
module dia_split import dia_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [24:0] u,
  output date_t       date
);

  logic [24:0] u_b;
  logic [7:0]  era_b, era_c, era_d, era_e;
  logic [17:0] doe_c, doe_d, doe_e, t_d;
  logic [8:0]  yoe_e, doy_f;
  logic [15:0] yb_f;

  logic [50:0] p_era;
  logic [24:0] era_days;
  logic [24:0] doe_full;
  logic [36:0] p_a, p_b, p_t;
  logic        c_last;
  logic [17:0] t_calc;
  logic [18:0] p_c;
  logic [17:0] doy_full;
  logic [15:0] yb_calc;
  logic [10:0] x5;
  logic [22:0] p_m;
  logic [3:0]  mp;
  logic [8:0]  day_full;
  date_t       date_next;

  assign p_era    = u * M_ERA;
  assign era_days = 25'(era_b) * ERA_DAYS;
  assign doe_full = u_b - era_days;

  assign p_a    = doe_c * M_1460;
  assign p_b    = doe_c * M_36524;
  assign c_last = (doe_c == 18'd146096);
  assign t_calc = doe_c - 18'(p_a[36:29]) + 18'(p_b[36:34]) - 18'(c_last);

  assign p_t = t_d * M_365;

  assign p_c      = 19'(yoe_e) * 19'(M_100S);
  assign doy_full = doe_e - (18'(yoe_e) * 18'd365 + 18'(yoe_e[8:2]) - 18'(p_c[18:16]));
  assign yb_calc  = 16'(yoe_e) + 16'(era_e) * 16'd400;

  assign x5       = 11'(doy_f) * 11'd5 + 11'd2;
  assign p_m      = 23'(x5) * 23'(M_153);
  assign mp       = p_m[22:19];
  assign day_full = doy_f - mday_tbl(mp) + 9'd1;

  always_comb begin
    date_next.day  = day_full[4:0];
    date_next.mon0 = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
    date_next.y    = $signed(17'(yb_f) - 17'(Y_OFS) + 17'(mp >= 4'd10));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_b   <= u;
      era_b <= p_era[50:43];
      doe_c <= doe_full[17:0];
      era_c <= era_b;
      t_d   <= t_calc;
      doe_d <= doe_c;
      era_d <= era_c;
      yoe_e <= p_t[35:27];
      doe_e <= doe_d;
      era_e <= era_d;
      doy_f <= doy_full[8:0];
      yb_f  <= yb_calc;
      date  <= date_next;
    end
  end

endmodule

// ----- hw/rtl/dia_build.sv -----
// pipelined clamp to month end and rebuild of the day count
`timescale 1ns / 1ps
module dia_build import dia_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  ymd_t        ymd,
  output logic [24:0] res
);

  logic [16:0] v_i, vp_i;
  logic [10:0] q100_i;
  logic [7:0]  era_i, era_j, era_k;
  logic [3:0]  mon_i;
  logic [4:0]  day_i;
  logic [8:0]  yoe_j, doy_j;
  logic [17:0] doe_k;

  logic [16:0] v_calc, vp_calc;
  logic [34:0] p_v, p_vp;
  logic [16:0] r100_full, yoe_full;
  logic        leap;
  logic [4:0]  lim, dc;
  logic [3:0]  mp2;
  logic [8:0]  doy_calc;
  logic [18:0] p_y;
  logic [17:0] doe_calc;
  logic [25:0] res_calc;

  assign v_calc  = 17'(ymd.y) + V_OFS;
  assign vp_calc = v_calc - 17'(ymd.mon <= 4'd2);
  assign p_v     = 35'(v_calc) * 35'(M_100);
  assign p_vp    = 35'(vp_calc) * 35'(M_400);

  assign r100_full = v_i - 17'(q100_i) * 17'd100;
  assign leap      = (v_i[1:0] == 2'd0) &&
                     ((r100_full[6:0] != 7'd0) || (q100_i[1:0] == 2'd0));
  assign lim       = month_len(mon_i, leap);
  assign dc        = (day_i > lim) ? lim : day_i;
  assign yoe_full  = vp_i - 17'(era_i) * 17'd400;
  assign mp2       = (mon_i > 4'd2) ? mon_i - 4'd3 : mon_i + 4'd9;
  assign doy_calc  = mday_tbl(mp2) + 9'(dc) - 9'd1;

  assign p_y      = 19'(yoe_j) * 19'(M_100S);
  assign doe_calc = 18'(yoe_j) * 18'd365 + 18'(yoe_j[8:2]) - 18'(p_y[18:16]) + 18'(doy_j);

  assign res_calc = 26'(era_k) * 26'(ERA_DAYS) + 26'(doe_k) - RES_OFS;

  always_ff @(posedge clk) begin
    if (en) begin
      v_i    <= v_calc;
      q100_i <= p_v[34:24];
      vp_i   <= vp_calc;
      era_i  <= p_vp[33:26];
      mon_i  <= ymd.mon;
      day_i  <= ymd.day;
      yoe_j  <= yoe_full[8:0];
      doy_j  <= doy_calc;
      era_j  <= era_i;
      doe_k  <= doe_calc;
      era_k  <= era_j;
      res    <= res_calc[24:0];
    end
  end

endmodule

// ----- hw/rtl/date_interval_add.sv -----
// top level of the date interval adder: input stage, side pipeline, month carry, output
`timescale 1ns / 1ps
//
// channel | handshake              | payload
// item    | item_valid, item_ready | func, start_days, amount
// result  | res_valid, res_ready   | result_days, status
//
// one transaction per cycle while not stalled, one result per transaction, in order
// path: input stage, six split stages, carry stage, four rebuild
//   stages, output register; the split into year/month/day is the longest part
// rst clears every valid bit; payload registers are not reset
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
module date_interval_add import dia_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] start_days,
  input  logic signed [31:0] amount,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [24:0] result_days,
  output logic [1:0]         status
);

  // global advance: whole pipeline moves unless the output is held
  logic en;
  assign en         = !res_valid || res_ready;
  assign item_ready = en;

  // input stage
  logic               start_bad;
  logic signed [32:0] dsum;
  logic [25:0]        us;
  side_t              sa, sa_next;
  logic [24:0]        u_a;

  assign start_bad = (33'(start_days) < DAYS_MIN) || (33'(start_days) > DAYS_MAX);
  assign dsum      = 33'(start_days) + 33'(amount);
  assign us        = 26'($signed(start_days[24:0])) + U_OFS;

  always_comb begin
    sa_next.valid     = item_valid;
    sa_next.func      = func_t'(func);
    sa_next.start_bad = start_bad;
    sa_next.day_bad   = (dsum < DAYS_MIN) || (dsum > DAYS_MAX);
    sa_next.day_res   = dsum[24:0];
    // month counts beyond 2^20 always leave the year range
    sa_next.amt_big   = !((&amount[31:20]) || (~|amount[31:20]));
    sa_next.amt       = amount;
    sa_next.ua        = 22'($signed(amount[20:0])) + UA_OFS;
    sa_next.q12       = '0;
    sa_next.add_m     = '0;
    sa_next.add_y     = '0;
  end

  // side pipeline, aligned with the split unit
  side_t       sb [SIDE_DEPTH];
  side_t       sb0_next, sb1_next;
  logic [44:0] p12;
  logic [21:0] rem12;

  assign p12   = 45'(sa.ua) * 45'(M_12);
  assign rem12 = sb[0].ua - 22'(sb[0].q12) * 22'd12;

  always_comb begin
    sb0_next     = sa;
    sb0_next.q12 = p12[43:26];
    sb1_next       = sb[0];
    sb1_next.add_m = rem12[3:0];
    sb1_next.add_y = $signed({1'b0, sb[0].q12}) - $signed(UA_QOFS);
  end

  date_t date;

  dia_split u_split (
    .clk  (clk),
    .en   (en),
    .u    (u_a),
    .date (date)
  );

  // month carry and year range check
  side_t              sl;
  logic [3:0]         addm;
  logic [4:0]         idx;
  logic               carry;
  logic signed [33:0] addy;
  logic signed [33:0] ny;
  tail_t              h, h_next;
  ymd_t               hy, hy_next;

  assign sl    = sb[SIDE_DEPTH-1];
  assign addm  = (sl.func == FN_MONTHS) ? sl.add_m : 4'd0;
  assign idx   = 5'(date.mon0) + 5'(addm);
  assign carry = (idx >= 5'd12);
  assign addy  = (sl.func == FN_YEARS) ? 34'(sl.amt) : 34'(sl.add_y);
  assign ny    = 34'(date.y) + addy + 34'(carry);

  always_comb begin
    h_next.valid     = sl.valid;
    h_next.func      = sl.func;
    h_next.start_bad = sl.start_bad;
    h_next.day_bad   = sl.day_bad;
    h_next.day_res   = sl.day_res;
    h_next.ymd_bad   = ((sl.func == FN_MONTHS) && sl.amt_big) ||
                       (ny < YEAR_MIN) || (ny > YEAR_MAX);
    hy_next.y   = ny[15:0];
    hy_next.mon = carry ? 4'(idx - 5'd11) : 4'(idx + 5'd1);
    hy_next.day = date.day;
  end

  logic [24:0] bres;

  dia_build u_build (
    .clk (clk),
    .en  (en),
    .ymd (hy),
    .res (bres)
  );

  // tail delay and output register
  tail_t       tq [TAIL_DEPTH];
  tail_t       tl;
  logic [24:0] res_next;
  status_t     st_next;

  assign tl = tq[TAIL_DEPTH-1];

  always_comb begin
    res_next = '0;
    st_next  = ST_OK;
    if (tl.start_bad) begin
      st_next = ST_RANGE;
    end else begin
      unique case (tl.func)
        FN_DAYS: begin
          if (tl.day_bad) st_next = ST_RANGE;
          else res_next = tl.day_res;
        end
        FN_MONTHS, FN_YEARS: begin
          if (tl.ymd_bad) st_next = ST_RANGE;
          else res_next = bres;
        end
        default: begin
          st_next = ST_UNIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid  <= 1'b0;
      h.valid   <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < SIDE_DEPTH; i++) begin
        sb[i].valid <= 1'b0;
      end
      for (int i = 0; i < TAIL_DEPTH; i++) begin
        tq[i].valid <= 1'b0;
      end
    end else if (en) begin
      sa    <= sa_next;
      u_a   <= us[24:0];
      sb[0] <= sb0_next;
      sb[1] <= sb1_next;
      for (int i = 2; i < SIDE_DEPTH; i++) begin
        sb[i] <= sb[i-1];
      end
      h     <= h_next;
      hy    <= hy_next;
      tq[0] <= h;
      for (int i = 1; i < TAIL_DEPTH; i++) begin
        tq[i] <= tq[i-1];
      end
      res_valid   <= tl.valid;
      result_days <= res_next;
      status      <= st_next;
    end
  end

  // failed transactions carry a zero date
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_OK) |-> (result_days == 25'sd0))
    else $error("non-zero date on failed transaction");

  // good results stay inside the reachable date span
  a_res_span: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_OK) |->
      (result_days >= -25'sd12800000 && result_days <= 25'sd11300000))
    else $error("result date outside reachable span");

  // nothing leaves the pipeline right after reset
  a_rst_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !res_valid)
    else $error("result valid straight after reset");

endmodule
